>>> rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int PATTERN_MAX_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;
   localparam int BYTE_W            = 8;
   localparam int OFFSET_W          = 16;

   typedef enum logic [0:0] {
      OP_PATTERN  = 1'b0,
      OP_HAYSTACK = 1'b1
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [BYTE_W-1:0]   data_byte;
      logic                last;
      logic [OFFSET_W-1:0] start_offset;
   } req_item_type;

endpackage

>>> rtl/bps_req_if.sv
// ----------------------------------------------------------------------------
// bps_req_if
// Request channel: pattern and haystack bytes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bps_req_if;
   import bps_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [BYTE_W-1:0]   data_byte;
   logic                last;
   logic [OFFSET_W-1:0] start_offset;

   modport source (output valid, operation, data_byte, last, start_offset, input ready);
   modport sink   (input valid, operation, data_byte, last, start_offset, output ready);

endinterface

>>> rtl/bps_rsp_if.sv
// ----------------------------------------------------------------------------
// bps_rsp_if
// Response channel: search result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bps_rsp_if;
   import bps_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);

endinterface

>>> rtl/byte_pattern_search.sv
// ----------------------------------------------------------------------------
// byte_pattern_search
// First occurrence of a loaded byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, pattern or haystack alike. The final haystack
// byte passes through the input register, then through the window compare
// into the result register. The compare of all PATTERN_MAX pattern lanes
// against the shifted window is parallel and combinational. A held result
// stalls the input only when the byte in the input register closes a
// haystack.
// ----------------------------------------------------------------------------
module byte_pattern_search #(
   parameter int PATTERN_MAX   = bps_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = bps_pkg::POSITION_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bps_req_if.sink    req_chan,
   bps_rsp_if.source  rsp_chan
);
   import bps_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CNT_W = POSITION_BITS + 1;
   localparam int CMP_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

   req_item_type                         s1_item_ff;
   logic                                 s1_valid_ff, s1_valid_in;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0]   pat_ff, pat_in;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0]   win_ff, win_in, win_shift;
   logic [LEN_W-1:0]                     len_ff, len_in, len_base;
   logic                                 closed_ff, closed_in;
   logic [OFFSET_W-1:0]                  ss_ff, ss_in;
   logic [CNT_W-1:0]                     pos_ff, pos_in;
   logic                                 seen_ff, seen_in;
   logic [OFFSET_W-1:0]                  mpos_ff, mpos_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic [OFFSET_W-1:0]                  rsp_pos_ff, rsp_pos_in;
   logic                                 req_fire, s1_makes_rsp, s1_take, rsp_load;
   logic                                 pat_shift, hit;
   logic [CMP_W-1:0]                     n_ext, n_plus, len_ext, ss_ext, p_ext;

   bps_window_cmp #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_cmp (
      .pattern     (pat_ff),
      .window      (win_ff),
      .data_byte   (s1_item_ff.data_byte),
      .length      (len_ff),
      .window_next (win_shift),
      .hit         (hit)
   );

   // handshake
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign s1_makes_rsp   = (s1_item_ff.operation == OP_HAYSTACK) && s1_item_ff.last;
   assign s1_take        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready || !s1_makes_rsp);
   assign rsp_load       = s1_take && s1_makes_rsp;
   assign req_chan.ready = !s1_valid_ff || s1_take;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || rsp_load;
   end

   // search state update
   always_comb begin
      len_in       = len_ff;
      closed_in    = closed_ff;
      ss_in        = ss_ff;
      win_in       = win_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      mpos_in      = mpos_ff;
      pat_shift    = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      len_base     = closed_ff ? '0 : len_ff;
      n_ext        = CMP_W'(pos_ff);
      n_plus       = n_ext + CMP_W'(1);
      len_ext      = CMP_W'(len_ff);
      ss_ext       = CMP_W'(ss_ff);
      p_ext        = n_plus - len_ext;

      if (s1_take) begin
         if (s1_item_ff.operation == OP_PATTERN) begin
            closed_in = 1'b0;
            len_in    = len_base;
            if (len_base != LEN_W'(PATTERN_MAX)) begin
               pat_shift = 1'b1;
               len_in    = len_base + LEN_W'(1);
            end
            if (s1_item_ff.last) begin
               ss_in     = s1_item_ff.start_offset;
               closed_in = 1'b1;
            end
         end else begin
            win_in = win_shift;
            if (!pos_ff[POSITION_BITS]) begin
               if (!seen_ff) begin
                  if (len_ff == '0) begin
                     if (n_ext >= ss_ext) begin
                        seen_in = 1'b1;
                        mpos_in = ss_ff;
                     end
                  end else if ((n_plus >= len_ext) && (p_ext >= ss_ext) && hit) begin
                     seen_in = 1'b1;
                     mpos_in = p_ext[OFFSET_W-1:0];
                  end
               end
               pos_in = pos_ff + CNT_W'(1);
            end
            if (s1_item_ff.last) begin
               rsp_found_in = seen_in;
               rsp_pos_in   = seen_in ? mpos_in : '0;
               win_in       = '0;
               pos_in       = '0;
               seen_in      = 1'b0;
               mpos_in      = '0;
            end
         end
      end
   end

   always_comb begin
      pat_in = pat_ff;
      if (pat_shift) begin
         pat_in[0] = s1_item_ff.data_byte;
         for (int j = 1; j < PATTERN_MAX; j++) begin
            pat_in[j] = pat_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         closed_ff    <= 1'b1;
         ss_ff        <= '0;
         win_ff       <= '0;
         pos_ff       <= '0;
         seen_ff      <= 1'b0;
         mpos_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         closed_ff    <= closed_in;
         ss_ff        <= ss_in;
         win_ff       <= win_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         mpos_ff      <= mpos_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (req_fire) begin
         s1_item_ff.operation    <= op_type'(req_chan.operation);
         s1_item_ff.data_byte    <= req_chan.data_byte;
         s1_item_ff.last         <= req_chan.last;
         s1_item_ff.start_offset <= req_chan.start_offset;
      end
      if (rsp_load) begin
         rsp_found_ff <= rsp_found_in;
         rsp_pos_ff   <= rsp_pos_in;
      end
   end

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(PATTERN_MAX))
      else $error("pattern length above maximum");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff[POSITION_BITS] |-> (pos_ff[POSITION_BITS-1:0] == '0))
      else $error("byte position past saturation");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_pos_ff == '0))
      else $error("position nonzero without match");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> ((pos_ff == '0) && !seen_ff && (mpos_ff == '0)))
      else $error("haystack state not cleared after result");

   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !rsp_load)
      else $error("result overwritten while held");
`endif

endmodule

>>> rtl/bps_window_cmp.sv
// ----------------------------------------------------------------------------
// bps_window_cmp
// Shift a haystack byte into the window and compare the aligned pattern
// against the newest bytes of the shifted window.
// ----------------------------------------------------------------------------
module bps_window_cmp #(
   parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
   parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  logic [PATTERN_MAX-1:0][bps_pkg::BYTE_W-1:0] pattern,
   input  logic [PATTERN_MAX-1:0][bps_pkg::BYTE_W-1:0] window,
   input  logic [bps_pkg::BYTE_W-1:0]                  data_byte,
   input  logic [LEN_W-1:0]                            length,
   output logic [PATTERN_MAX-1:0][bps_pkg::BYTE_W-1:0] window_next,
   output logic                                        hit
);
   import bps_pkg::*;

   logic [PATTERN_MAX-1:0] lane_ok;

   always_comb begin
      window_next[0] = data_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         window_next[j] = window[j-1];
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         lane_ok[j] = (LEN_W'(j) >= length) || (pattern[j] == window_next[j]);
      end
   end

   assign hit = &lane_ok;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_pattern_search. A directed table covers the
// empty pattern, field extremes, the start offset, earliest-match-only and a
// pattern loaded mid-haystack. Random pattern/haystack searches follow, with
// planted matches, overlong patterns and stray pattern bytes. Every result is
// compared against its table entry or an in-bench search predictor, with
// random idling on both sides of the block except during a steady stretch.
// ----------------------------------------------------------------------------
module testbench;
   import bps_pkg::*;

   localparam int PATTERN_MAX    = PATTERN_MAX_DEF;
   localparam int POSITION_BITS  = POSITION_BITS_DEF;
   localparam int COUNT_LIMIT    = 1 << POSITION_BITS;
   localparam int IDLE_PCT       = 18;
   localparam int RANDOM_ITEMS   = 450;
   localparam int DIRECTED_COUNT = 20;
   localparam logic FROM_MODEL   = 1'b0;
   localparam logic FROM_TABLE   = 1'b1;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] position;
   } search_result_type;

   typedef struct packed {
      op_type              operation;
      logic [BYTE_W-1:0]   data_byte;
      logic                last;
      logic [OFFSET_W-1:0] start_offset;
      logic                typed;
      logic                want_found;
      logic [OFFSET_W-1:0] want_position;
   } table_row_type;

   localparam table_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_HAYSTACK, 8'h00, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h55, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'hFF, 1'b1, 16'h0000, FROM_TABLE, 1'b1, 16'h0000},
      '{OP_PATTERN,  8'hFF, 1'b0, 16'hFFFF, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_PATTERN,  8'h00, 1'b1, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h00, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'hFF, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h00, 1'b1, 16'h0000, FROM_TABLE, 1'b1, 16'h0001},
      '{OP_PATTERN,  8'hAA, 1'b1, 16'hFFFF, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'hAA, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'hAA, 1'b1, 16'h0000, FROM_TABLE, 1'b0, 16'h0000},
      '{OP_PATTERN,  8'h3C, 1'b1, 16'h0001, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h3C, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h3C, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h11, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h3C, 1'b1, 16'h0000, FROM_TABLE, 1'b1, 16'h0001},
      '{OP_HAYSTACK, 8'h77, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_PATTERN,  8'h77, 1'b0, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_HAYSTACK, 8'h77, 1'b1, 16'h0000, FROM_MODEL, 1'b0, 16'h0000},
      '{OP_PATTERN,  8'h01, 1'b1, 16'h0000, FROM_MODEL, 1'b0, 16'h0000}
   };

   logic clock;
   logic reset;

   bps_req_if req_bus ();
   bps_rsp_if rsp_bus ();

   byte_pattern_search dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // search predictor state
   logic [BYTE_W-1:0]   pattern_bytes [PATTERN_MAX];
   int                  pattern_len;
   logic [OFFSET_W-1:0] search_from;
   logic                pattern_done;
   logic [BYTE_W-1:0]   recent_bytes [PATTERN_MAX];
   int                  bytes_taken;
   logic                hit_seen;
   logic [OFFSET_W-1:0] hit_position;

   search_result_type   pending_results [$];
   logic                row_typed;
   search_result_type   row_want;
   logic                steady;
   int                  items_sent;
   int                  mismatches;

   task automatic search_step(input req_item_type item, output logic emit,
                              output search_result_type result);
      int   first;
      logic agree;
      emit   = 1'b0;
      result = '0;
      if (item.operation == OP_PATTERN) begin
         if (pattern_done) begin
            pattern_len  = 0;
            pattern_done = 1'b0;
         end
         if (pattern_len < PATTERN_MAX) begin
            pattern_bytes[pattern_len] = item.data_byte;
            pattern_len++;
         end
         if (item.last) begin
            search_from  = item.start_offset;
            pattern_done = 1'b1;
         end
      end else begin
         for (int i = PATTERN_MAX - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i - 1];
         recent_bytes[0] = item.data_byte;
         if (bytes_taken < COUNT_LIMIT) begin
            if (!hit_seen) begin
               if (pattern_len == 0) begin
                  if (bytes_taken >= search_from) begin
                     hit_seen     = 1'b1;
                     hit_position = search_from;
                  end
               end else if (bytes_taken + 1 >= pattern_len) begin
                  first = bytes_taken + 1 - pattern_len;
                  agree = 1'b1;
                  for (int k = 0; k < pattern_len; k++) begin
                     if (pattern_bytes[k] != recent_bytes[pattern_len - 1 - k]) agree = 1'b0;
                  end
                  if (first >= search_from && agree) begin
                     hit_seen     = 1'b1;
                     hit_position = first[OFFSET_W-1:0];
                  end
               end
            end
            bytes_taken++;
         end
         if (item.last) begin
            emit            = 1'b1;
            result.found    = hit_seen;
            result.position = hit_seen ? hit_position : '0;
            foreach (recent_bytes[i]) recent_bytes[i] = '0;
            bytes_taken  = 0;
            hit_seen     = 1'b0;
            hit_position = '0;
         end
      end
   endtask

   // drive at the falling edge, hold until the transfer
   task automatic send_byte(input op_type operation, input logic [BYTE_W-1:0] data_byte,
                            input logic last, input logic [OFFSET_W-1:0] start_offset,
                            input logic typed, input search_result_type want);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= operation;
      req_bus.data_byte    <= data_byte;
      req_bus.last         <= last;
      req_bus.start_offset <= start_offset;
      row_typed            <= typed;
      row_want             <= want;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_model(input op_type operation, input logic [BYTE_W-1:0] data_byte,
                             input logic last, input logic [OFFSET_W-1:0] start_offset);
      send_byte(operation, data_byte, last, start_offset, FROM_MODEL, '0);
   endtask

   task automatic random_search();
      logic [BYTE_W-1:0]   motif [$];
      logic [BYTE_W-1:0]   hay [$];
      logic [OFFSET_W-1:0] offset;
      int                  motif_len;
      int                  stored_len;
      int                  hay_len;
      int                  place;
      logic                late;
      logic                open_end;
      late      = items_sent > DIRECTED_COUNT + RANDOM_ITEMS - 60;
      motif_len = ($urandom_range(9) == 0) ? $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4)
                                           : $urandom_range(1, 5);
      stored_len = (motif_len > PATTERN_MAX) ? PATTERN_MAX : motif_len;
      for (int i = 0; i < motif_len; i++) motif.push_back(BYTE_W'($urandom_range(0, 255)));
      offset   = ($urandom_range(7) == 0) ? OFFSET_W'($urandom_range(0, 65535))
                                          : OFFSET_W'($urandom_range(0, 6));
      open_end = !late && $urandom_range(11) == 0;
      for (int i = 0; i < motif_len; i++) begin
         if (i == motif_len - 1 && !open_end) send_model(OP_PATTERN, motif[i], 1'b1, offset);
         else send_model(OP_PATTERN, motif[i], 1'b0, OFFSET_W'($urandom_range(0, 65535)));
      end

      hay_len = (motif_len > PATTERN_MAX) ? $urandom_range(PATTERN_MAX, 40)
                                          : $urandom_range(1, 24);
      for (int i = 0; i < hay_len; i++) begin
         hay.push_back($urandom_range(1) ? motif[$urandom_range(0, motif_len - 1)]
                                         : BYTE_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(2) != 0 && hay_len >= stored_len) begin
         place = $urandom_range(0, hay_len - stored_len);
         for (int i = 0; i < stored_len; i++) hay[place + i] = motif[i];
      end
      for (int i = 0; i < hay_len; i++) begin
         if (!late && $urandom_range(29) == 0)
            send_model(OP_PATTERN, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(1)),
                       OFFSET_W'($urandom_range(0, 65535)));
         send_model(OP_HAYSTACK, hay[i], i == hay_len - 1,
                    OFFSET_W'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      req_item_type      item;
      search_result_type predicted;
      search_result_type wanted;
      logic              emit;
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         item = '{op_type'(req_bus.operation), req_bus.data_byte, req_bus.last,
                  req_bus.start_offset};
         search_step(item, emit, predicted);
         if (emit) pending_results.push_back(row_typed ? row_want : predicted);
      end
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result found=%0d position=%0d", $time,
                     rsp_bus.found, rsp_bus.position);
            mismatches++;
         end else begin
            wanted = pending_results.pop_front();
            if (rsp_bus.found !== wanted.found) begin
               $display("%0t: found mismatch: expected %0d, got %0d", $time,
                        wanted.found, rsp_bus.found);
               mismatches++;
            end
            if (rsp_bus.position !== wanted.position) begin
               $display("%0t: position mismatch: expected %0d, got %0d", $time,
                        wanted.position, rsp_bus.position);
               mismatches++;
            end
         end
      end
   end

   initial begin
      table_row_type row;
      int            searches;
      foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
      foreach (recent_bytes[i]) recent_bytes[i] = '0;
      pattern_len          = 0;
      search_from          = '0;
      pattern_done         = 1'b1;
      bytes_taken          = 0;
      hit_seen             = 1'b0;
      hit_position         = '0;
      row_typed            = FROM_MODEL;
      row_want             = '0;
      steady               = 1'b0;
      items_sent           = 0;
      mismatches           = 0;
      searches             = 0;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_PATTERN;
      req_bus.data_byte    = '0;
      req_bus.last         = 1'b0;
      req_bus.start_offset = '0;
      reset                = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         send_byte(row.operation, row.data_byte, row.last, row.start_offset, row.typed,
                   {row.want_found, row.want_position});
      end
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);

      while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
         steady = searches >= 20 && searches < 32;
         random_search();
         searches++;
      end

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
